/* hdl/rmmm_pkg.sv */
// shared constants, codes and types for the running mean / median / mode block
// no dependencies
package rmmm_pkg;
  localparam int CAP    = 64;
  localparam int IDX_W  = $clog2(CAP);
  localparam int CNT_W  = 7;
  localparam int VAL_W  = 32;
  localparam int SUM_W  = 38;
  localparam int DIV_W  = SUM_W + 8;
  localparam int DCNT_W = $clog2(DIV_W);
  localparam int MEAN_W = 40;
  localparam int MED_W  = 33;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_REM = 1'b1;

  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_INS  = 2'd1;
  localparam logic [1:0] CELL_REM  = 2'd2;
  localparam logic [1:0] CELL_ROT  = 2'd3;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [VAL_W-1:0] v;
  } cell_ctl_t;
endpackage

/* hdl/rmmm_cell.sv */
// one cell of the sorted chain: holds a single sample, shifts with its neighbors
// depends on rmmm_pkg
module rmmm_cell (
  input  logic                             clk,
  input  rmmm_pkg::cell_ctl_t              ctl,
  input  logic                             in_range,
  input  logic                             at_end,
  input  logic                             left_gt,
  input  logic signed [rmmm_pkg::VAL_W-1:0] left_val,
  input  logic signed [rmmm_pkg::VAL_W-1:0] right_val,
  output logic signed [rmmm_pkg::VAL_W-1:0] val,
  output logic                             gt
);
  import rmmm_pkg::*;

  logic signed [VAL_W-1:0] val_r, val_nxt;

  assign val = val_r;
  assign gt  = in_range && (val_r > ctl.v);

  always_comb begin
    val_nxt = val_r;
    case (ctl.op)
      CELL_INS: begin
        // cells from the insert point up move one place right
        if (gt || at_end) begin
          val_nxt = left_gt ? left_val : ctl.v;
        end
      end
      CELL_REM: begin
        if (in_range && (val_r >= ctl.v)) begin
          val_nxt = right_val;
        end
      end
      CELL_ROT: val_nxt = right_val;
      default:  val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end
endmodule

/* hdl/rmmm_div.sv */
// restoring divider, one quotient bit a cycle, sign applied at the end
// depends on rmmm_pkg
module rmmm_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [rmmm_pkg::DIV_W-1:0]         mag,
  input  logic                               neg,
  input  logic [rmmm_pkg::CNT_W-1:0]         divisor,
  output logic signed [rmmm_pkg::MEAN_W-1:0] quot,
  output logic                               done
);
  import rmmm_pkg::*;

  logic              busy_r, busy_nxt, done_r, done_nxt, neg_r, neg_nxt;
  logic [DCNT_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt, d_r, d_nxt;
  logic [DIV_W-1:0]  q_r, q_nxt, q_neg;
  logic [CNT_W:0]    rem_sh;

  assign rem_sh = {rem_r, q_r[DIV_W-1]};
  assign q_neg  = neg_r ? (~q_r + DIV_W'(1)) : q_r;
  assign quot   = q_neg[MEAN_W-1:0];
  assign done   = done_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    neg_nxt  = neg_r;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      neg_nxt  = neg;
      step_nxt = '0;
      rem_nxt  = '0;
      d_nxt    = divisor;
      q_nxt    = mag;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, d_r}) begin
        rem_nxt = CNT_W'(rem_sh - {1'b0, d_r});
        q_nxt   = {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[CNT_W-1:0];
        q_nxt   = {q_r[DIV_W-2:0], 1'b0};
      end
      step_nxt = step_r + DCNT_W'(1);
      if (step_r == DCNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    neg_r  <= neg_nxt;
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    d_r    <= d_nxt;
    q_r    <= q_nxt;
  end
endmodule

/* hdl/running_mean_median_mode.sv */
// running mean / median / mode over a sorted multiset held in a chain of cells
// an item passes the update state, the rotating scan of the 64-cell chain, the finish state and the output register
// a new item is taken only in idle, so not before the result of the last one is registered for output
// the mean divider runs inside the scan
// reset: synchronous active-low rst_n clears count, sum and mode; cells need no clear
// depends on rmmm_pkg, rmmm_cell, rmmm_div
module running_mean_median_mode (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // cmd[0], value[32:1], zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata   // status[1:0], count[8:2], mean_fixed[48:9],
                                   // median_times_two[81:49], mode_value[113:82], zero pad
);
  import rmmm_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_OP   = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic                    cmd_r, cmd_nxt;
  logic signed [VAL_W-1:0] v_r, v_nxt;
  logic [1:0]              status_r, status_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [VAL_W-1:0] mode_r, mode_nxt;
  logic [CNT_W-1:0]        mode_n_r, mode_n_nxt;
  logic [IDX_W-1:0]        k_r, k_nxt;
  logic [CNT_W-1:0]        occ_r, occ_nxt, run_r, run_nxt, best_n_r, best_n_nxt;
  logic signed [VAL_W-1:0] prev_r, prev_nxt, best_r, best_nxt;
  logic signed [VAL_W-1:0] med_a_r, med_a_nxt, med_b_r, med_b_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [119:0]            out_data_r, out_data_nxt;

  cell_ctl_t               ctl;
  logic signed [VAL_W-1:0] vals [CAP];
  logic [CAP-1:0]          gts, eqs;
  logic                    present;

  // chain of cells
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic in_range, at_end;
    assign in_range = (CNT_W'(i) < cnt_r);
    assign at_end   = (CNT_W'(i) == cnt_r);
    assign eqs[i]   = in_range && (vals[i] == v_r);
    rmmm_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .in_range  (in_range),
      .at_end    (at_end),
      .left_gt   ((i == 0) ? 1'b0 : gts[(i == 0) ? 0 : i - 1]),
      .left_val  ((i == 0) ? v_r : vals[(i == 0) ? 0 : i - 1]),
      .right_val ((i == CAP - 1) ? vals[0] : vals[(i == CAP - 1) ? 0 : i + 1]),
      .val       (vals[i]),
      .gt        (gts[i])
    );
  end

  assign present = |eqs;

  // mean divider
  logic signed [DIV_W-1:0]  dividend;
  logic [DIV_W-1:0]         div_mag;
  logic signed [MEAN_W-1:0] div_q;
  logic                     div_done, div_start;

  assign dividend  = {sum_r, 8'd0};
  assign div_mag   = dividend[DIV_W-1] ? (~dividend + DIV_W'(1)) : dividend;
  assign div_start = (state_r == S_SCAN) && (k_r == '0);

  rmmm_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .mag     (div_mag),
    .neg     (dividend[DIV_W-1]),
    .divisor (cnt_r),
    .quot    (div_q),
    .done    (div_done)
  );

  logic signed [VAL_W-1:0] x;
  logic                    x_in;
  logic [CNT_W-1:0]        run_new, idx_a, idx_b;
  logic signed [MED_W-1:0] med2;

  assign x       = vals[0];
  assign x_in    = ({1'b0, k_r} < cnt_r);
  assign run_new = ((k_r == '0) || (x != prev_r)) ? CNT_W'(1) : run_r + CNT_W'(1);
  assign idx_a   = (cnt_r - CNT_W'(1)) >> 1;
  assign idx_b   = cnt_r >> 1;
  assign med2    = MED_W'(med_a_r) + MED_W'(med_b_r);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    v_nxt         = v_r;
    status_nxt    = status_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    mode_nxt      = mode_r;
    mode_n_nxt    = mode_n_r;
    k_nxt         = k_r;
    occ_nxt       = occ_r;
    run_nxt       = run_r;
    best_n_nxt    = best_n_r;
    prev_nxt      = prev_r;
    best_nxt      = best_r;
    med_a_nxt     = med_a_r;
    med_b_nxt     = med_b_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ctl.op        = CELL_HOLD;
    ctl.v         = v_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = in_tdata[0];
          v_nxt     = in_tdata[32:1];
          state_nxt = S_OP;
        end
      end
      S_OP: begin
        status_nxt = ST_DONE;
        if (cmd_r == CMD_ADD) begin
          if (cnt_r == CNT_W'(CAP)) begin
            status_nxt = ST_FULL;
          end else begin
            ctl.op  = CELL_INS;
            cnt_nxt = cnt_r + CNT_W'(1);
            sum_nxt = sum_r + SUM_W'(v_r);
          end
        end else begin
          if (!present) begin
            status_nxt = ST_ABSENT;
          end else begin
            ctl.op  = CELL_REM;
            cnt_nxt = cnt_r - CNT_W'(1);
            sum_nxt = sum_r - SUM_W'(v_r);
          end
        end
        k_nxt      = '0;
        occ_nxt    = '0;
        best_n_nxt = '0;
        best_nxt   = '0;
        state_nxt  = S_SCAN;
      end
      S_SCAN: begin
        // chain rotates one place a cycle, cell 0 shows entry k
        ctl.op = CELL_ROT;
        if (x_in) begin
          if (x == v_r) begin
            occ_nxt = occ_r + CNT_W'(1);
          end
          run_nxt  = run_new;
          prev_nxt = x;
          if (run_new > best_n_r) begin
            best_n_nxt = run_new;
            best_nxt   = x;
          end
        end
        if ({1'b0, k_r} == idx_a) begin
          med_a_nxt = x;
        end
        if ({1'b0, k_r} == idx_b) begin
          med_b_nxt = x;
        end
        k_nxt = k_r + IDX_W'(1);
        if (k_r == IDX_W'(CAP - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          if (status_r == ST_DONE) begin
            if (cmd_r == CMD_ADD) begin
              if (v_r == mode_r) begin
                mode_n_nxt = occ_r;
              end else if (occ_r > mode_n_r) begin
                mode_nxt   = v_r;
                mode_n_nxt = occ_r;
              end
            end else if (v_r == mode_r) begin
              mode_nxt   = best_r;
              mode_n_nxt = best_n_r;
            end
          end
          out_data_nxt          = '0;
          out_data_nxt[1:0]     = status_r;
          out_data_nxt[8:2]     = cnt_r;
          if (cnt_r != '0) begin
            out_data_nxt[48:9]    = div_q;
            out_data_nxt[81:49]   = med2;
            out_data_nxt[113:82]  = mode_nxt;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sum_r       <= '0;
      mode_r      <= '0;
      mode_n_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      mode_r      <= mode_nxt;
      mode_n_r    <= mode_n_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    v_r        <= v_nxt;
    status_r   <= status_nxt;
    k_r        <= k_nxt;
    occ_r      <= occ_nxt;
    run_r      <= run_nxt;
    best_n_r   <= best_n_nxt;
    prev_r     <= prev_nxt;
    best_r     <= best_nxt;
    med_a_r    <= med_a_nxt;
    med_b_r    <= med_b_nxt;
    out_data_r <= out_data_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAP))
    else $error("held count above capacity");

  a_div_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> div_done)
    else $error("mean divider not finished at result time");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r[1:0] == ST_FULL)) |-> (out_data_r[8:2] == CNT_W'(CAP)))
    else $error("full status reported below capacity");

  a_empty_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && cnt_r == '0 && (!out_valid_r || out_tready)) |=> (mode_r == '0))
    else $error("mode not cleared on empty store");
endmodule
